// File: rtl/core/flb_pkg.sv
// shared types and codes for the free list buffer pool
// no dependencies; imported by the pool top level
`default_nettype none

package flb_pkg;

    localparam int IDX_W    = 4;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 5;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ALLOC_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FREE_EMPTY  = 2'd3;

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_FETCH
    } t_state;

    typedef struct packed {
        logic [IDX_W-1:0]    granted_index;
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    in_use_count;
        logic [CNT_W-1:0]    high_water;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/core/free_list_buffer_pool.sv
// free list buffer pool: link store in flb_ram, head and counters in flops
// the result word is registered; it waits in the skid word while the output stalls
// throughput: a free every cycle while no skid word is held; an allocate that pops
// stalls the input in S_FETCH, since the link of the new head comes back from the
// ram read port in the cycle after the pop; reset: a sweep rewrites every entry
// of the link store, no word taken; depends on flb_pkg and flb_ram
`default_nettype none

module free_list_buffer_pool
    import flb_pkg::*;
#(
    parameter int POOL_SIZE = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic                i_func,
    input  wire logic [IDX_W-1:0]    i_free_index,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic      [IDX_W-1:0]    o_granted_index,
    output logic      [STATUS_W-1:0] o_status,
    output logic      [CNT_W-1:0]    o_in_use_count,
    output logic      [CNT_W-1:0]    o_high_water
);

    localparam int IW = $clog2(POOL_SIZE);
    localparam int CW = $clog2(POOL_SIZE + 1);
    localparam logic [CW-1:0] POOL_CNT = CW'(POOL_SIZE);
    localparam logic [IW-1:0] TOP_IDX  = IW'(POOL_SIZE - 1);
    localparam logic [IW-1:0] TOP_LINK = IW'(POOL_SIZE - 2);

    t_state r_state, n_state;

    logic [IW-1:0] r_init_cnt, n_init_cnt;
    logic [IW-1:0] r_head, n_head;
    logic [IW-1:0] r_head_link, n_head_link;
    logic [CW-1:0] r_in_use, n_in_use;
    logic [CW-1:0] r_peak, n_peak;

    logic          r_out_valid, r_skid_valid;
    t_result       r_out, r_skid, res;

    logic          mem_we;
    logic [IW-1:0] mem_waddr, mem_wdata, mem_rdata;

    logic accept, take, is_alloc, full, empty, push, pop;

    assign accept   = i_in_valid && !o_in_stall;
    assign take     = r_out_valid && !i_out_stall;
    assign is_alloc = (i_func == FUNC_ALLOC);
    assign full     = (r_in_use >= POOL_CNT);
    assign empty    = (r_in_use == '0);
    assign pop      = accept && is_alloc && !full;
    assign push     = accept && !is_alloc && !empty && (i_free_index != '0)
                      && (32'(i_free_index) < POOL_SIZE);

    flb_ram #(
        .WIDTH (IW),
        .DEPTH (POOL_SIZE)
    ) u_link (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_head_link),
        .o_rdata (mem_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (r_init_cnt == TOP_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (pop) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: n_state = S_IDLE;
            default: n_state = S_INIT;
        endcase
    end

    // outputs of the state machine: handshake and ram write port
    always_comb begin
        o_in_stall = 1'b1;
        mem_we     = 1'b0;
        mem_waddr  = IW'(i_free_index);
        mem_wdata  = r_head;
        case (r_state)
            S_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = r_init_cnt;
                mem_wdata = (r_init_cnt == '0) ? '0 : r_init_cnt - 1'b1;
            end
            S_IDLE: begin
                o_in_stall = r_skid_valid;
                mem_we     = push;
            end
            S_FETCH: o_in_stall = 1'b1;
            default: o_in_stall = 1'b1;
        endcase
    end

    // pool state update and result word
    always_comb begin
        n_init_cnt  = r_init_cnt;
        n_head      = r_head;
        n_head_link = r_head_link;
        n_in_use    = r_in_use;
        n_peak      = r_peak;
        res.granted_index = '0;
        res.status        = ST_OK;

        if (r_state == S_INIT) begin
            n_init_cnt  = r_init_cnt + 1'b1;
            n_head      = TOP_IDX;
            n_head_link = TOP_LINK;
        end
        if (r_state == S_FETCH) begin
            n_head_link = mem_rdata;
        end

        if (accept) begin
            if (is_alloc) begin
                if (full) begin
                    res.status = ST_ALLOC_FULL;
                end else begin
                    res.granted_index = IDX_W'(r_head);
                    res.status        = (r_head == '0) ? ST_OVERFLOW : ST_OK;
                    n_head            = r_head_link;
                    n_in_use          = r_in_use + 1'b1;
                    if (n_in_use > r_peak) begin
                        n_peak = n_in_use;
                    end
                end
            end else begin
                if (empty) begin
                    res.status = ST_FREE_EMPTY;
                end else begin
                    n_in_use = r_in_use - 1'b1;
                    if (push) begin
                        n_head      = IW'(i_free_index);
                        n_head_link = r_head;
                    end
                end
            end
        end

        res.in_use_count = CNT_W'(n_in_use);
        res.high_water   = CNT_W'(n_peak);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_init_cnt <= '0;
            r_in_use   <= '0;
            r_peak     <= '0;
        end else begin
            r_state    <= n_state;
            r_init_cnt <= n_init_cnt;
            r_in_use   <= n_in_use;
            r_peak     <= n_peak;
        end
        r_head      <= n_head;
        r_head_link <= n_head_link;
    end

    // output register with one skid word behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= accept;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take || !r_out_valid) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (accept) begin
            r_skid <= res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_granted_index = r_out.granted_index;
    assign o_status        = r_out.status;
    assign o_in_use_count  = r_out.in_use_count;
    assign o_high_water    = r_out.high_water;

    a_pop_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> (r_state == S_FETCH))
        else $error("pop did not refresh head link");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_use <= POOL_CNT)
        else $error("in-use count above pool size");

    a_peak_ge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak >= r_in_use)
        else $error("high-water mark below in-use count");

    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held with output register empty");

    a_init_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> o_in_stall)
        else $error("word accepted during link store sweep");

endmodule

`default_nettype wire

// File: rtl/core/flb_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module flb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
